[rtl/lbfdb_pkg.sv]
// ----------------------------------------------------------------------------
// lbfdb_pkg
// Shared widths, codes and link types of the learning bridge forwarding table.
// ----------------------------------------------------------------------------
package lbfdb_pkg;

  // field widths
  localparam int MAC_W     = 48;
  localparam int PORT_W    = 3;
  localparam int MASK_W    = 8;
  localparam int LEN_W     = 16;
  localparam int CNT_W     = 32;
  localparam int CMD_W     = 2;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 48;

  // stream word widths, padded to whole bytes
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 144;

  // parameter defaults
  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int PORT_COUNT_DEF    = 8;

  localparam logic [LEN_W-1:0] MIN_FRAME_LEN = 16'd14;
  localparam int               GROUP_BIT     = 40;
  localparam logic [MAC_W-1:0] OWN_MAC_RESET = 48'h0200_0300_0000;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PORT_FRAME  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STACK_FRAME = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PORT_REMOVE = 2'd2;

  // forwarding kinds
  localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UNICAST = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLOOD   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIDGE_UP    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEMBER_MASK  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_UP_MASK = 8'd3;

  // command broadcast to every table cell
  typedef struct packed {
    logic              learn_en;
    logic              clear_en;
    logic [MAC_W-1:0]  learn_mac;
    logic [PORT_W-1:0] port;
    logic [MAC_W-1:0]  look_mac;
  } cell_ctl_t;

  // learn ripple: a matching entry or a free entry seen so far
  typedef struct packed {
    logic hit;
    logic free;
  } learn_link_t;

  // lookup ripple: first matching entry and its port
  typedef struct packed {
    logic              found;
    logic [PORT_W-1:0] port;
  } look_link_t;

  // ports that exist on this bridge
  function automatic logic [MASK_W-1:0] port_range_mask(input int count);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int b = 0; b < MASK_W; b++) begin
      m[b] = (b < count);
    end
    return m;
  endfunction

endpackage

[rtl/lbfdb_cell.sv]
// ----------------------------------------------------------------------------
// lbfdb_cell
// One forwarding table entry with its learn, clear and lookup logic.
// ----------------------------------------------------------------------------
module lbfdb_cell #(
  parameter bit HEAD = 1'b0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  lbfdb_pkg::cell_ctl_t    ctl,
  input  lbfdb_pkg::learn_link_t  learn_i,
  output lbfdb_pkg::learn_link_t  learn_o,
  input  lbfdb_pkg::learn_link_t  learn_sum,
  input  lbfdb_pkg::look_link_t   look_i,
  output lbfdb_pkg::look_link_t   look_o,
  output logic                    look_hit
);
  import lbfdb_pkg::*;

  logic              valid;
  logic [MAC_W-1:0]  mac;
  logic [PORT_W-1:0] port;

  logic learn_match;
  logic write_en;
  logic clear_hit;

  // learn: first match updates, else first free entry, else the head entry
  assign learn_match = valid && (mac == ctl.learn_mac);
  assign learn_o.hit  = learn_i.hit  | learn_match;
  assign learn_o.free = learn_i.free | !valid;

  assign write_en = ctl.learn_en &&
                    ((learn_match && !learn_i.hit) ||
                     (!learn_sum.hit && !valid && !learn_i.free) ||
                     (HEAD && !learn_sum.hit && !learn_sum.free));

  assign clear_hit = ctl.clear_en && valid && (port == ctl.port);

  // lookup: pass the first hit down the chain
  assign look_hit     = valid && (mac == ctl.look_mac);
  assign look_o.found = look_i.found | look_hit;
  assign look_o.port  = (!look_i.found && look_hit) ? port : look_i.port;

  // entry storage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      mac   <= '0;
      port  <= '0;
    end else if (write_en) begin
      valid <= 1'b1;
      mac   <= ctl.learn_mac;
      port  <= ctl.port;
    end else if (clear_hit) begin
      valid <= 1'b0;
      mac   <= '0;
      port  <= '0;
    end
  end

endmodule

[rtl/lbfdb_chain.sv]
// ----------------------------------------------------------------------------
// lbfdb_chain
// Row of table cells linked by the learn and lookup ripples.
// ----------------------------------------------------------------------------
module lbfdb_chain #(
  parameter int TABLE_ENTRIES = lbfdb_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lbfdb_pkg::cell_ctl_t       ctl,
  output lbfdb_pkg::look_link_t      look,
  output logic [TABLE_ENTRIES-1:0]   look_hits
);
  import lbfdb_pkg::*;

  learn_link_t learn_link [TABLE_ENTRIES+1];
  look_link_t  look_link  [TABLE_ENTRIES+1];

  // chain heads start empty
  assign learn_link[0] = '0;
  assign look_link[0]  = '0;

  // cells
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    lbfdb_cell #(
      .HEAD (i == 0)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .learn_i   (learn_link[i]),
      .learn_o   (learn_link[i+1]),
      .learn_sum (learn_link[TABLE_ENTRIES]),
      .look_i    (look_link[i]),
      .look_o    (look_link[i+1]),
      .look_hit  (look_hits[i])
    );
  end

  assign look = look_link[TABLE_ENTRIES];

endmodule

[rtl/learning_bridge_fdb_unit.sv]
// ----------------------------------------------------------------------------
// learning_bridge_fdb_unit
// Learning bridge forwarding table with egress decision and frame counters.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command word per frame header (port frame, stack frame
//   or port removal). m_axis returns one result word per command with the
//   egress port mask, local delivery flag, forwarding kind and the four
//   counters after that command. cfg writes own_mac, bridge_up, member_mask
//   and port_up_mask by index; write only while no command is in flight.
//   Each command makes one learn/clear pass through the cell row, then one
//   lookup pass whose result is loaded into the output register. The next
//   command is taken in the cycle the previous result is loaded, so commands
//   run back to back while m_axis does not stall.
//   Reset clears every table entry, the counters and the output valid flag,
//   and loads the register reset values. If m_axis stalls, the result waits
//   in the output register and the next command waits in its lookup cycle.
// ----------------------------------------------------------------------------
module learning_bridge_fdb_unit #(
  parameter int TABLE_ENTRIES = lbfdb_pkg::TABLE_ENTRIES_DEF,
  parameter int PORT_COUNT    = lbfdb_pkg::PORT_COUNT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // cmd, in_port, dst_mac, src_mac, frame_len
  input  logic [lbfdb_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // accepted, egress_mask, to_local, forward_kind,
  // tx_count, rx_count, flood_count, unicast_count
  output logic [lbfdb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lbfdb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lbfdb_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import lbfdb_pkg::*;

  localparam logic [MASK_W-1:0] ALL_PORTS = port_range_mask(PORT_COUNT);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEARN,
    S_LOOK
  } state_t;

  state_t state;

  // configuration registers
  logic [MAC_W-1:0]  own_mac;
  logic              bridge_up;
  logic [MASK_W-1:0] member_mask;
  logic [MASK_W-1:0] port_up_mask;

  // current command
  logic [CMD_W-1:0]  it_cmd;
  logic [PORT_W-1:0] it_port;
  logic [MAC_W-1:0]  it_dst;
  logic [MAC_W-1:0]  it_src;
  logic [LEN_W-1:0]  it_len;

  // counters
  logic [CNT_W-1:0] tx_total, rx_total, flood_total, unicast_total;
  logic [CNT_W-1:0] tx_next, rx_next, flood_next, unicast_next;

  cell_ctl_t                ctl;
  look_link_t               look;
  logic [TABLE_ENTRIES-1:0] look_hits;

  logic              commit;
  logic              in_take;
  logic              len_ok;
  logic              group;
  logic              for_us;
  logic              fwd;
  logic              has_in;
  logic              acc;
  logic              to_local;
  logic [KIND_W-1:0] kind;
  logic [MASK_W-1:0] in_bit;
  logic [MASK_W-1:0] elig;
  logic [MASK_W-1:0] egress;

  // handshakes
  assign commit        = (state == S_LOOK) && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = (state == S_IDLE) || commit;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // table command
  assign len_ok = (it_len >= MIN_FRAME_LEN);
  assign group  = it_dst[GROUP_BIT];
  assign for_us = (it_dst == own_mac);

  assign ctl.learn_en  = (state == S_LEARN) && (it_cmd == CMD_PORT_FRAME) &&
                         bridge_up && len_ok && !it_src[GROUP_BIT];
  assign ctl.clear_en  = (state == S_LEARN) && (it_cmd == CMD_PORT_REMOVE);
  assign ctl.learn_mac = it_src;
  assign ctl.port      = it_port;
  assign ctl.look_mac  = it_dst;

  lbfdb_chain #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .look      (look),
    .look_hits (look_hits)
  );

  // forwarding decision and counter updates
  assign in_bit = MASK_W'(1) << it_port;

  always_comb begin
    acc          = 1'b0;
    to_local     = 1'b0;
    fwd          = 1'b0;
    has_in       = 1'b0;
    kind         = KIND_NONE;
    egress       = '0;
    tx_next      = tx_total;
    rx_next      = rx_total;
    flood_next   = flood_total;
    unicast_next = unicast_total;
    case (it_cmd)
      CMD_PORT_FRAME: begin
        if (bridge_up && len_ok) begin
          acc      = 1'b1;
          rx_next  = rx_total + CNT_W'(1);
          fwd      = group || !for_us;
          has_in   = 1'b1;
          to_local = group || for_us;
        end
      end
      CMD_STACK_FRAME: begin
        if (len_ok) begin
          acc     = 1'b1;
          tx_next = tx_total + CNT_W'(1);
          fwd     = 1'b1;
        end
      end
      CMD_PORT_REMOVE: begin
        acc = 1'b1;
      end
      default: begin
      end
    endcase
    elig = member_mask & port_up_mask & ALL_PORTS;
    if (has_in) begin
      elig = elig & ~in_bit;
    end
    if (fwd) begin
      if (!group && look.found) begin
        kind         = KIND_UNICAST;
        unicast_next = unicast_total + CNT_W'(1);
        egress       = elig & (MASK_W'(1) << look.port);
      end else begin
        kind       = KIND_FLOOD;
        flood_next = flood_total + CNT_W'(1);
        egress     = elig;
      end
    end
  end

  // sequencer, command capture, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      tx_total      <= '0;
      rx_total      <= '0;
      flood_total   <= '0;
      unicast_total <= '0;
    end else begin
      if (commit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            state <= S_LEARN;
          end
        end
        S_LEARN: begin
          state <= S_LOOK;
        end
        S_LOOK: begin
          if (commit) begin
            m_axis_tdata  <= {4'b0, unicast_next, flood_next, rx_next, tx_next,
                              kind, to_local, egress, acc};
            tx_total      <= tx_next;
            rx_total      <= rx_next;
            flood_total   <= flood_next;
            unicast_total <= unicast_next;
            state         <= in_take ? S_LEARN : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
    if (in_take) begin
      it_cmd  <= s_axis_tdata[1:0];
      it_port <= s_axis_tdata[4:2];
      it_dst  <= s_axis_tdata[52:5];
      it_src  <= s_axis_tdata[100:53];
      it_len  <= s_axis_tdata[116:101];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac      <= OWN_MAC_RESET;
      bridge_up    <= 1'b0;
      member_mask  <= '0;
      port_up_mask <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OWN_MAC:      own_mac      <= cfg_data[MAC_W-1:0];
        REG_BRIDGE_UP:    bridge_up    <= cfg_data[0];
        REG_MEMBER_MASK:  member_mask  <= cfg_data[MASK_W-1:0];
        REG_PORT_UP_MASK: port_up_mask <= cfg_data[MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // learned addresses stay unique, so a lookup never hits twice
  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK) |-> $onehot0(look_hits))
    else $error("more than one table entry matches the lookup address");

  // an accepted port frame bumps the rx counter by exactly one
  a_rx_step: assert property (@(posedge clk) disable iff (rst)
    (commit && (it_cmd == CMD_PORT_FRAME) && acc) |=>
      (rx_total == $past(rx_total) + CNT_W'(1)))
    else $error("rx counter did not advance on an accepted port frame");

  // outside idle, a new word is only taken when the result slot can drain
  a_take_slot: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> ((state == S_IDLE) || !m_axis_tvalid || m_axis_tready))
    else $error("command taken while the result register is blocked");

  // a fresh result only appears out of the lookup cycle
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == S_LOOK))
    else $error("result word raised outside the lookup cycle");

endmodule

[tb/learning_bridge_fdb_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// learning_bridge_fdb_unit_tb
// Drives forwarding table commands through the stream ports under random
// stalls and register settings. Every result word is compared field by field
// with a behavioral bridge that learns and looks up stations alongside the
// block.
// ----------------------------------------------------------------------------
module learning_bridge_fdb_unit_tb;
  import lbfdb_pkg::*;

  localparam int TABLE_SIZE       = 16;
  localparam int BRIDGE_PORTS     = 8;
  localparam int STATIONS         = 20;
  localparam int MAX_REPORTS      = 10;
  localparam int LONG_HOLD_AT     = 300;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT      = 500000;

  localparam logic [CMD_W-1:0]     CMD_UNUSED    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'hFC;
  localparam logic [MASK_W-1:0]    PORT_SPAN     = MASK_W'((1 << BRIDGE_PORTS) - 1);
  localparam logic [MAC_W-1:0]     BROADCAST     = {MAC_W{1'b1}};

  // command word, cmd in the lowest bits
  typedef struct packed {
    logic [LEN_W-1:0]  frame_len;
    logic [MAC_W-1:0]  src_mac;
    logic [MAC_W-1:0]  dst_mac;
    logic [PORT_W-1:0] in_port;
    logic [CMD_W-1:0]  cmd;
  } fdb_cmd_t;

  // result word, accepted in the lowest bit
  typedef struct packed {
    logic [CNT_W-1:0]  unicast_count;
    logic [CNT_W-1:0]  flood_count;
    logic [CNT_W-1:0]  rx_count;
    logic [CNT_W-1:0]  tx_count;
    logic [KIND_W-1:0] forward_kind;
    logic              to_local;
    logic [MASK_W-1:0] egress_mask;
    logic              accepted;
  } fdb_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // mirrored registers
  logic [MAC_W-1:0]  cfg_own_mac = OWN_MAC_RESET;
  logic              cfg_bridge_up = 1'b0;
  logic [MASK_W-1:0] cfg_member_mask = '0;
  logic [MASK_W-1:0] cfg_port_up_mask = '0;

  // mirrored forwarding table and counters
  logic [MAC_W-1:0]  fdb_mac [TABLE_SIZE];
  logic [PORT_W-1:0] fdb_port [TABLE_SIZE];
  logic              fdb_valid [TABLE_SIZE];
  logic [CNT_W-1:0]  tx_total = '0;
  logic [CNT_W-1:0]  rx_total = '0;
  logic [CNT_W-1:0]  flood_total = '0;
  logic [CNT_W-1:0]  unicast_total = '0;

  fdb_cmd_t    pending_cmds [$];
  fdb_result_t expected_results [$];
  fdb_cmd_t    offered_cmd;
  fdb_result_t got_result;
  fdb_result_t want_result;
  logic [MAC_W-1:0] station [STATIONS];

  int items_queued = 0;
  int results_checked = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int gap_pct = 0;
  bit quiet = 1'b0;
  int s_gap_left = 0;
  int r_hold_left = 0;
  bit long_hold_done = 1'b0;

  learning_bridge_fdb_unit #(
    .TABLE_ENTRIES(TABLE_SIZE),
    .PORT_COUNT   (BRIDGE_PORTS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // unicast lookup, else flood; counts the frame and returns the egress ports
  function automatic logic [MASK_W-1:0] route_frame(input logic [MAC_W-1:0] dst,
                                                    input logic from_port,
                                                    input logic [PORT_W-1:0] port,
                                                    output logic [KIND_W-1:0] kind);
    logic [MASK_W-1:0] ok;
    int hit;
    ok = cfg_member_mask & cfg_port_up_mask & PORT_SPAN;
    if (from_port) ok[port] = 1'b0;
    hit = -1;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (hit < 0 && !dst[GROUP_BIT] && fdb_valid[i] && fdb_mac[i] == dst) hit = i;
    end
    if (hit >= 0) begin
      unicast_total++;
      kind = KIND_UNICAST;
      return ok & (MASK_W'(1) << fdb_port[hit]);
    end
    flood_total++;
    kind = KIND_FLOOD;
    return ok;
  endfunction

  // bridge behavior for one command, updates the mirrored table
  function automatic fdb_result_t predict_result(input fdb_cmd_t c);
    fdb_result_t r;
    logic group;
    logic for_us;
    int slot;
    r = '0;
    case (c.cmd)
      CMD_PORT_FRAME: begin
        if (cfg_bridge_up && c.frame_len >= MIN_FRAME_LEN) begin
          group = c.dst_mac[GROUP_BIT];
          for_us = (c.dst_mac == cfg_own_mac);
          r.accepted = 1'b1;
          rx_total++;
          // learn unicast source: moved station, else first free, else entry 0
          if (!c.src_mac[GROUP_BIT]) begin
            slot = -1;
            for (int i = 0; i < TABLE_SIZE; i++) begin
              if (slot < 0 && fdb_valid[i] && fdb_mac[i] == c.src_mac) slot = i;
            end
            if (slot < 0) begin
              for (int i = 0; i < TABLE_SIZE; i++) begin
                if (slot < 0 && !fdb_valid[i]) slot = i;
              end
              if (slot < 0) slot = 0;
              fdb_mac[slot] = c.src_mac;
              fdb_valid[slot] = 1'b1;
            end
            fdb_port[slot] = c.in_port;
          end
          if (group || !for_us)
            r.egress_mask = route_frame(c.dst_mac, 1'b1, c.in_port, r.forward_kind);
          r.to_local = group || for_us;
        end
      end
      CMD_STACK_FRAME: begin
        if (c.frame_len >= MIN_FRAME_LEN) begin
          r.accepted = 1'b1;
          tx_total++;
          r.egress_mask = route_frame(c.dst_mac, 1'b0, '0, r.forward_kind);
        end
      end
      CMD_PORT_REMOVE: begin
        r.accepted = 1'b1;
        for (int i = 0; i < TABLE_SIZE; i++) begin
          if (fdb_valid[i] && fdb_port[i] == c.in_port) begin
            fdb_valid[i] = 1'b0;
            fdb_mac[i] = '0;
            fdb_port[i] = '0;
          end
        end
      end
      default: begin
      end
    endcase
    r.tx_count = tx_total;
    r.rx_count = rx_total;
    r.flood_count = flood_total;
    r.unicast_count = unicast_total;
    return r;
  endfunction

  // address mix: known stations mostly, own address, random and group ones
  function automatic logic [MAC_W-1:0] pick_mac();
    int sel;
    logic [MAC_W-1:0] mac;
    sel = $urandom_range(0, 99);
    mac = MAC_W'({$urandom, $urandom});
    if (sel < 70) return station[$urandom_range(0, STATIONS - 1)];
    if (sel < 80) return mac;
    if (sel < 87) return cfg_own_mac;
    if (sel < 93) return BROADCAST;
    mac[GROUP_BIT] = 1'b1;
    return mac;
  endfunction

  function automatic fdb_cmd_t random_command();
    fdb_cmd_t c;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 62) c.cmd = CMD_PORT_FRAME;
    else if (sel < 88) c.cmd = CMD_STACK_FRAME;
    else if (sel < 96) c.cmd = CMD_PORT_REMOVE;
    else c.cmd = CMD_UNUSED;
    c.in_port = PORT_W'($urandom_range(0, BRIDGE_PORTS - 1));
    c.dst_mac = pick_mac();
    c.src_mac = pick_mac();
    sel = $urandom_range(0, 99);
    if (sel < 8) c.frame_len = LEN_W'($urandom_range(0, 13));
    else if (sel < 12) c.frame_len = sel[0] ? MIN_FRAME_LEN : {LEN_W{1'b1}};
    else if (sel < 25) c.frame_len = LEN_W'($urandom_range(14, 65535));
    else c.frame_len = LEN_W'($urandom_range(60, 1518));
    return c;
  endfunction

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [PORT_W-1:0] port,
                           input logic [MAC_W-1:0] dst, input logic [MAC_W-1:0] src,
                           input logic [LEN_W-1:0] len);
    fdb_cmd_t c;
    c.cmd = cmd;
    c.in_port = port;
    c.dst_mac = dst;
    c.src_mac = src;
    c.frame_len = len;
    pending_cmds.push_back(c);
    items_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_OWN_MAC:      cfg_own_mac = val;
      REG_BRIDGE_UP:    cfg_bridge_up = val[0];
      REG_MEMBER_MASK:  cfg_member_mask = val[MASK_W-1:0];
      REG_PORT_UP_MASK: cfg_port_up_mask = val[MASK_W-1:0];
      default: begin
      end
    endcase
  endtask

  // upper data bits carry noise that the block must ignore
  task automatic set_bridge(input logic [MAC_W-1:0] mac, input logic up,
                            input logic [MASK_W-1:0] members, input logic [MASK_W-1:0] ups);
    logic [CFG_DATA_W-1:0] noise;
    noise = CFG_DATA_W'({$urandom, $urandom});
    write_reg(REG_OWN_MAC, mac);
    write_reg(REG_BRIDGE_UP, {noise[CFG_DATA_W-1:1], up});
    write_reg(REG_MEMBER_MASK, {noise[CFG_DATA_W-1:MASK_W], members});
    write_reg(REG_PORT_UP_MASK, {~noise[CFG_DATA_W-1:MASK_W], ups});
  endtask

  // every queued command answered, then let the pipeline settle
  task automatic drain();
    while (results_checked != items_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("word %0d %s: expected %0h, got %0h", results_checked, what, want, got);
  endtask

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(predict_result(offered_cmd));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (s_gap_left > 0) begin
          s_gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < gap_pct) begin
          s_gap_left = $urandom_range(0, 17);
          s_axis_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          offered_cmd = pending_cmds.pop_front();
          s_axis_tdata <= IN_TDATA_W'(offered_cmd);
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      r_hold_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_result = fdb_result_t'(m_axis_tdata[$bits(fdb_result_t)-1:0]);
        if (expected_results.size() == 0) begin
          report_mismatch("arrived with nothing pending", '0, 64'(got_result.rx_count));
        end else begin
          want_result = expected_results.pop_front();
          if (got_result.accepted !== want_result.accepted)
            report_mismatch("accepted", want_result.accepted, got_result.accepted);
          if (got_result.egress_mask !== want_result.egress_mask)
            report_mismatch("egress_mask", want_result.egress_mask, got_result.egress_mask);
          if (got_result.to_local !== want_result.to_local)
            report_mismatch("to_local", want_result.to_local, got_result.to_local);
          if (got_result.forward_kind !== want_result.forward_kind)
            report_mismatch("forward_kind", want_result.forward_kind, got_result.forward_kind);
          if (got_result.tx_count !== want_result.tx_count)
            report_mismatch("tx_count", want_result.tx_count, got_result.tx_count);
          if (got_result.rx_count !== want_result.rx_count)
            report_mismatch("rx_count", want_result.rx_count, got_result.rx_count);
          if (got_result.flood_count !== want_result.flood_count)
            report_mismatch("flood_count", want_result.flood_count, got_result.flood_count);
          if (got_result.unicast_count !== want_result.unicast_count)
            report_mismatch("unicast_count", want_result.unicast_count,
                            got_result.unicast_count);
          results_checked++;
        end
      end
      // one long hold-off so the block backs up into its input
      if (!long_hold_done && results_checked >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        r_hold_left = LONG_HOLD_CYCLES;
      end
      if (r_hold_left > 0) begin
        r_hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < gap_pct) begin
        r_hold_left = $urandom_range(0, 17);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    fdb_cmd_t c;
    int count;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      fdb_mac[i] = '0;
      fdb_port[i] = '0;
      fdb_valid[i] = 1'b0;
    end
    for (int i = 0; i < STATIONS; i++) begin
      station[i] = MAC_W'({$urandom, $urandom});
      station[i][GROUP_BIT] = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: bridge down, no ports
    queue_cmd(CMD_PORT_FRAME, 3'd0, station[1], station[0], 16'd64);
    queue_cmd(CMD_STACK_FRAME, 3'd0, station[0], OWN_MAC_RESET, MIN_FRAME_LEN);
    queue_cmd(CMD_STACK_FRAME, 3'd0, station[0], OWN_MAC_RESET, 16'd13);
    drain();

    // directed cases with all ports up
    set_bridge(station[19], 1'b1, 8'hFF, 8'hFF);
    queue_cmd(CMD_PORT_FRAME, 3'd0, station[1], station[0], MIN_FRAME_LEN);
    queue_cmd(CMD_PORT_FRAME, 3'd7, station[0], station[1], 16'hFFFF);
    queue_cmd(CMD_PORT_FRAME, 3'd3, station[19], station[2], 16'd60);
    queue_cmd(CMD_PORT_FRAME, 3'd3, BROADCAST, station[3], 16'd60);
    queue_cmd(CMD_PORT_FRAME, 3'd2, station[0], BROADCAST, 16'd60);
    // learned port is the arrival port
    queue_cmd(CMD_PORT_FRAME, 3'd0, station[0], station[0], 16'd60);
    // station moves from port 0 to port 5
    queue_cmd(CMD_PORT_FRAME, 3'd5, station[1], station[0], 16'd60);
    queue_cmd(CMD_STACK_FRAME, 3'd0, station[0], station[19], MIN_FRAME_LEN);
    queue_cmd(CMD_PORT_FRAME, 3'd4, '0, '0, 16'd13);
    queue_cmd(CMD_PORT_FRAME, 3'd4, '0, '0, '0);
    queue_cmd(CMD_PORT_FRAME, 3'd6, station[2], '0, 16'd100);
    queue_cmd(CMD_STACK_FRAME, 3'd0, '0, station[19], 16'd100);
    queue_cmd(CMD_STACK_FRAME, 3'd0, station[19], station[19], 16'hFFFF);
    queue_cmd(CMD_PORT_REMOVE, 3'd5, '0, '0, '0);
    queue_cmd(CMD_STACK_FRAME, 3'd0, station[0], station[19], 16'd60);
    queue_cmd(CMD_PORT_REMOVE, 3'd1, BROADCAST, BROADCAST, 16'hFFFF);
    queue_cmd(CMD_UNUSED, 3'd7, BROADCAST, BROADCAST, 16'hFFFF);
    queue_cmd(CMD_PORT_FRAME, 3'd7, 48'h0100_0000_0000, station[1], 16'd60);
    drain();

    // random phases, each under its own register setting
    for (int p = 0; p < 6; p++) begin
      count = 210;
      case (p)
        0: set_bridge(MAC_W'({$urandom, $urandom}), 1'b1, 8'hFF, 8'hFF);
        1: begin
          write_reg(CFG_IDX_SPARE, CFG_DATA_W'({$urandom, $urandom}));
          set_bridge('0, 1'b1, MASK_W'($urandom), MASK_W'($urandom));
        end
        2: begin
          set_bridge(BROADCAST, 1'b0, 8'h00, 8'h00);
          count = 60;
        end
        3: set_bridge(station[0], 1'b1, MASK_W'($urandom), MASK_W'($urandom));
        4: set_bridge(MAC_W'({$urandom, $urandom}), 1'b1, 8'hFF, MASK_W'($urandom));
        default: set_bridge(station[5], 1'b1, MASK_W'($urandom) | 8'h0F, 8'hFF);
      endcase
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 15;
        default: gap_pct = 40;
      endcase
      repeat (count) begin
        c = random_command();
        queue_cmd(c.cmd, c.in_port, c.dst_mac, c.src_mac, c.frame_len);
      end
      drain();
    end

    // closing stretch at full rate
    quiet = 1'b1;
    gap_pct = 0;
    set_bridge(station[1], 1'b1, 8'hFF, 8'hFF);
    repeat (150) begin
      c = random_command();
      queue_cmd(c.cmd, c.in_port, c.dst_mac, c.src_mac, c.frame_len);
    end
    drain();
    repeat (10) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
